// ===== src/arp_pkg.sv =====
// ============================================================================
// arp_pkg: shared types and constants of the ARP table responder
// Command and action codes, ARP field values, controller state type and the
// command/status bundles between controller and datapath.
// ============================================================================
package arp_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;

   // item commands
   localparam logic [1:0] CMD_RX_PACKET = 2'd0;
   localparam logic [1:0] CMD_LOOKUP    = 2'd1;
   localparam logic [1:0] CMD_SEND_REQ  = 2'd2;

   // result actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_REPLY   = 2'd1;
   localparam logic [1:0] ACT_REQUEST = 2'd2;
   localparam logic [1:0] ACT_LOOKUP  = 2'd3;

   // ARP header values
   localparam logic [15:0] HW_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4  = 16'h0800;
   localparam logic [15:0] OP_REQUEST  = 16'd1;
   localparam logic [15:0] OP_REPLY    = 16'd2;
   localparam logic [1:0]  TX_OP_REQUEST = 2'd1;
   localparam logic [1:0]  TX_OP_REPLY   = 2'd2;
   localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

   // register select (paddr bit 3)
   localparam logic REG_OWN_IP  = 1'b0;
   localparam logic REG_OWN_MAC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_RESPOND
   } arp_state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic respond;
   } arp_cmd_type;

   typedef struct packed {
      logic need_search;
      logic search_done;
   } arp_stat_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } arp_entry_type;

endpackage

// ===== src/arp_csr.sv =====
// ============================================================================
// arp_csr: station address registers
// Holds own_ip and own_mac, written and read over the APB-style port.
// ============================================================================
module arp_csr
   import arp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output logic [31:0] own_ip
);

   logic [31:0] own_ip_ff, own_ip_in;
   logic [47:0] own_mac_ff, own_mac_in;
   logic        wr_en;

   always_comb begin
      wr_en      = psel && penable && pwrite;
      own_ip_in  = own_ip_ff;
      own_mac_in = own_mac_ff;
      if (wr_en) begin
         unique case (paddr[3])
            REG_OWN_IP:  own_ip_in  = pwdata[31:0];
            REG_OWN_MAC: own_mac_in = pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else begin
         own_ip_ff  <= own_ip_in;
         own_mac_ff <= own_mac_in;
      end
   end

   always_comb begin
      unique case (paddr[3])
         REG_OWN_IP:  prdata = {32'd0, own_ip_ff};
         REG_OWN_MAC: prdata = {16'd0, own_mac_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready  = 1'b1;
   assign own_ip  = own_ip_ff;

endmodule

// ===== src/arp_ctrl.sv =====
// ============================================================================
// arp_ctrl: item sequencer
// Steps each transaction through decode, table search and response.
// ============================================================================
module arp_ctrl
   import arp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  arp_stat_type stat,
   output arp_cmd_type  cmd,
   output logic         busy
);

   arp_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_DECODE;
         ST_DECODE:  state_in = stat.need_search ? ST_SEARCH : ST_RESPOND;
         ST_SEARCH:  if (stat.search_done) state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DECODE:  ;
         ST_SEARCH:  cmd.search  = 1'b1;
         ST_RESPOND: cmd.respond = 1'b1;
         default:    ;
      endcase
   end

endmodule

// ===== src/arp_dpath.sv =====
// ============================================================================
// arp_dpath: item registers, address table and result registers
// Latches the transaction, scans the table one entry a cycle through a
// registered read port, then updates the table and builds the result.
// ============================================================================
module arp_dpath
   import arp_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)(
   input  logic         clock,
   input  logic         reset,
   input  arp_cmd_type  cmd,
   output arp_stat_type stat,
   input  logic [31:0]  own_ip,
   input  logic [1:0]   req_command,
   input  logic [15:0]  req_op_code,
   input  logic [15:0]  req_hw_type,
   input  logic [15:0]  req_proto_type,
   input  logic [47:0]  req_sender_mac,
   input  logic [31:0]  req_sender_ip,
   input  logic [31:0]  req_query_ip,
   output logic         rsp_valid,
   output logic [1:0]   rsp_action,
   output logic [47:0]  rsp_tx_dest_mac,
   output logic [1:0]   rsp_tx_op,
   output logic [31:0]  rsp_tx_target_ip,
   output logic         rsp_found,
   output logic [47:0]  rsp_found_mac,
   output logic         rsp_table_full
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(TABLE_ENTRIES);

   // latched transaction
   logic [1:0]  command_ff;
   logic [15:0] op_code_ff, hw_type_ff, proto_type_ff;
   logic [47:0] sender_mac_ff;
   logic [31:0] sender_ip_ff, query_ip_ff;

   // table and search state
   arp_entry_type    entry_mem_ff [TABLE_ENTRIES];
   arp_entry_type    rd_entry_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issued_ff, issued_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [47:0]      hit_mac_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [1:0]  action_ff, action_in;
   logic [47:0] dest_mac_ff, dest_mac_in;
   logic [1:0]  tx_op_ff, tx_op_in;
   logic [31:0] target_ip_ff, target_ip_in;
   logic        found_ff, found_in;
   logic [47:0] found_mac_ff, found_mac_in;
   logic        full_ff, full_in;

   logic             types_ok, is_req, is_rep, has_room;
   logic [31:0]      key_ip;
   logic             issue, match;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   arp_entry_type    wr_entry;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff    <= req_command;
         op_code_ff    <= req_op_code;
         hw_type_ff    <= req_hw_type;
         proto_type_ff <= req_proto_type;
         sender_mac_ff <= req_sender_mac;
         sender_ip_ff  <= req_sender_ip;
         query_ip_ff   <= req_query_ip;
      end
   end

   always_comb begin
      types_ok = (hw_type_ff == HW_ETHERNET) && (proto_type_ff == PROTO_IPV4);
      is_req   = (command_ff == CMD_RX_PACKET) && types_ok && (op_code_ff == OP_REQUEST);
      is_rep   = (command_ff == CMD_RX_PACKET) && types_ok && (op_code_ff == OP_REPLY);
      key_ip   = (command_ff == CMD_LOOKUP) ? query_ip_ff : sender_ip_ff;
      has_room = (count_ff < COUNT_MAX);

      issue = cmd.search && (issued_ff < count_ff);
      match = cmp_valid_ff && (rd_entry_ff.ip == key_ip);

      stat.need_search = (command_ff == CMD_LOOKUP) || is_rep;
      stat.search_done = match || (!cmp_valid_ff && (issued_ff == count_ff));
   end

   // search sequencing: issue one read per cycle, compare the previous read
   always_comb begin
      issued_in    = issued_ff;
      cmp_valid_in = 1'b0;
      hit_in       = hit_ff;
      if (cmd.load) begin
         issued_in = '0;
         hit_in    = 1'b0;
      end else if (cmd.search) begin
         cmp_valid_in = issue;
         if (issue) issued_in = issued_ff + CNT_W'(1);
         if (match) hit_in = 1'b1;
      end
   end

   // table update on the response cycle of a learned reply
   always_comb begin
      wr_en          = cmd.respond && is_rep && (hit_ff || has_room);
      wr_addr        = hit_ff ? hit_idx_ff : count_ff[IDX_W-1:0];
      wr_entry.ip    = sender_ip_ff;
      wr_entry.mac   = sender_mac_ff;
      count_in       = count_ff;
      if (cmd.respond && is_rep && !hit_ff && has_room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_entry_ff <= entry_mem_ff[issued_ff[IDX_W-1:0]];
         cmp_idx_ff  <= issued_ff[IDX_W-1:0];
      end
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (cmd.search && match && !hit_ff) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_mac_ff <= rd_entry_ff.mac;
      end
   end

   always_comb begin
      action_in    = ACT_NONE;
      dest_mac_in  = '0;
      tx_op_in     = '0;
      target_ip_in = '0;
      found_in     = 1'b0;
      found_mac_in = '0;
      full_in      = 1'b0;
      priority if (is_req) begin
         if (query_ip_ff == own_ip) begin
            action_in    = ACT_REPLY;
            dest_mac_in  = sender_mac_ff;
            tx_op_in     = TX_OP_REPLY;
            target_ip_in = sender_ip_ff;
         end
      end else if (is_rep) begin
         full_in = !hit_ff && !has_room;
      end else if (command_ff == CMD_LOOKUP) begin
         action_in    = ACT_LOOKUP;
         found_in     = hit_ff;
         found_mac_in = hit_ff ? hit_mac_ff : '0;
      end else if (command_ff == CMD_SEND_REQ) begin
         action_in    = ACT_REQUEST;
         dest_mac_in  = BROADCAST_MAC;
         tx_op_in     = TX_OP_REQUEST;
         target_ip_in = query_ip_ff;
      end else begin
         action_in = ACT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         action_ff    <= action_in;
         dest_mac_ff  <= dest_mac_in;
         tx_op_ff     <= tx_op_in;
         target_ip_ff <= target_ip_in;
         found_ff     <= found_in;
         found_mac_ff <= found_mac_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issued_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issued_ff    <= issued_in;
         cmp_valid_ff <= cmp_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_tx_dest_mac  = dest_mac_ff;
   assign rsp_tx_op        = tx_op_ff;
   assign rsp_tx_target_ip = target_ip_ff;
   assign rsp_found        = found_ff;
   assign rsp_found_mac    = found_mac_ff;
   assign rsp_table_full   = full_ff;

   a_respond_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> rsp_valid_ff)
      else $error("response cycle did not raise the result strobe");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond table size");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && full_ff) |-> (count_ff == COUNT_MAX && action_ff == ACT_NONE))
      else $error("table_full flagged while space remains");

   a_found_only_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (action_ff == ACT_LOOKUP))
      else $error("found set on a non-lookup result");

endmodule

// ===== src/arp_table_responder.sv =====
// ============================================================================
// arp_table_responder: ARP cache and responder for IPv4 over Ethernet
// Learns IPv4-to-MAC pairs from ARP replies, answers requests for own_ip,
// serves lookups and builds broadcast request descriptors.
// ============================================================================
// Busy stays high from accept through decode, any table search and the response
//   state; a lookup or reply searches the table, stopping at the first hit or
//   after the entries held, at once with the table empty.
// The result strobe is high in the first cycle with busy low again; it cannot
//   stall.
// Reset: synchronous; clears the entry count, station registers and strobe.
module arp_table_responder
   import arp_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_op_code,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_proto_type,
   input  logic [47:0] req_sender_mac,
   input  logic [31:0] req_sender_ip,
   input  logic [31:0] req_query_ip,
   output logic        rsp_valid,
   output logic [1:0]  rsp_action,
   output logic [47:0] rsp_tx_dest_mac,
   output logic [1:0]  rsp_tx_op,
   output logic [31:0] rsp_tx_target_ip,
   output logic        rsp_found,
   output logic [47:0] rsp_found_mac,
   output logic        rsp_table_full,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   arp_cmd_type  cmd;
   arp_stat_type stat;
   logic [31:0]  own_ip;

   arp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .own_ip  (own_ip)
   );

   arp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   arp_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .own_ip           (own_ip),
      .req_command      (req_command),
      .req_op_code      (req_op_code),
      .req_hw_type      (req_hw_type),
      .req_proto_type   (req_proto_type),
      .req_sender_mac   (req_sender_mac),
      .req_sender_ip    (req_sender_ip),
      .req_query_ip     (req_query_ip),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_tx_dest_mac  (rsp_tx_dest_mac),
      .rsp_tx_op        (rsp_tx_op),
      .rsp_tx_target_ip (rsp_tx_target_ip),
      .rsp_found        (rsp_found),
      .rsp_found_mac    (rsp_found_mac),
      .rsp_table_full   (rsp_table_full)
   );

endmodule

// ===== test/tb_arp_table_responder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_arp_table_responder: self-checking testbench of the ARP table responder
// Drives received ARP packets, lookups and send-request commands through the
// start/busy port and register writes through the APB port. Each accepted
// transaction is run through a local model of the table and responder, and
// every result strobe is compared field by field with the oldest prediction.
// ============================================================================
module tb_arp_table_responder;
   import arp_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int POOL_SIZE = 24;
   localparam int RANDOM_PHASES = 5;
   localparam int ITEMS_PER_PHASE = 226;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] op_code;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] query_ip;
   } arp_item_t;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] tx_dest_mac;
      logic [1:0]  tx_op;
      logic [31:0] tx_target_ip;
      logic        found;
      logic [47:0] found_mac;
      logic        table_full;
   } arp_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [15:0] req_op_code = '0;
   logic [15:0] req_hw_type = '0;
   logic [15:0] req_proto_type = '0;
   logic [47:0] req_sender_mac = '0;
   logic [31:0] req_sender_ip = '0;
   logic [31:0] req_query_ip = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_action;
   logic [47:0] rsp_tx_dest_mac;
   logic [1:0]  rsp_tx_op;
   logic [31:0] rsp_tx_target_ip;
   logic        rsp_found;
   logic [47:0] rsp_found_mac;
   logic        rsp_table_full;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   // local copy of the station registers and the cache
   logic [31:0] own_ip_cfg = '0;
   logic [47:0] own_mac_cfg = '0;
   logic [31:0] held_ip [TABLE_ENTRIES];
   logic [47:0] held_mac [TABLE_ENTRIES];
   int          held_count = 0;

   arp_result_t pending_responses [$];
   logic [31:0] ip_pool [POOL_SIZE];
   int          gap_max = 7;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          n_sent = 0;
   int          n_results = 0;
   int          n_replies = 0;
   int          n_hits = 0;
   int          n_drops = 0;
   int          n_settings = 0;

   arp_table_responder uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_op_code      (req_op_code),
      .req_hw_type      (req_hw_type),
      .req_proto_type   (req_proto_type),
      .req_sender_mac   (req_sender_mac),
      .req_sender_ip    (req_sender_ip),
      .req_query_ip     (req_query_ip),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_tx_dest_mac  (rsp_tx_dest_mac),
      .rsp_tx_op        (rsp_tx_op),
      .rsp_tx_target_ip (rsp_tx_target_ip),
      .rsp_found        (rsp_found),
      .rsp_found_mac    (rsp_found_mac),
      .rsp_table_full   (rsp_table_full),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // lowest held index for ip, or -1
   function automatic int find_entry(input logic [31:0] ip);
      int idx;
      idx = -1;
      for (int k = held_count - 1; k >= 0; k--) begin
         if (held_ip[k] == ip) idx = k;
      end
      return idx;
   endfunction

   task automatic predict_arp_response(input arp_item_t it, output arp_result_t r);
      int   idx;
      logic types_ok;
      r = '0;
      types_ok = (it.hw_type == HW_ETHERNET) && (it.proto_type == PROTO_IPV4);
      case (it.command)
         CMD_RX_PACKET: begin
            if (types_ok && it.op_code == OP_REQUEST) begin
               if (it.query_ip == own_ip_cfg) begin
                  r.action       = ACT_REPLY;
                  r.tx_dest_mac  = it.sender_mac;
                  r.tx_op        = TX_OP_REPLY;
                  r.tx_target_ip = it.sender_ip;
                  n_replies++;
               end
            end else if (types_ok && it.op_code == OP_REPLY) begin
               idx = find_entry(it.sender_ip);
               if (idx >= 0) begin
                  held_mac[idx] = it.sender_mac;
               end else if (held_count < TABLE_ENTRIES) begin
                  held_ip[held_count]  = it.sender_ip;
                  held_mac[held_count] = it.sender_mac;
                  held_count++;
               end else begin
                  r.table_full = 1'b1;
                  n_drops++;
               end
            end
         end
         CMD_LOOKUP: begin
            r.action = ACT_LOOKUP;
            idx = find_entry(it.query_ip);
            if (idx >= 0) begin
               r.found     = 1'b1;
               r.found_mac = held_mac[idx];
               n_hits++;
            end
         end
         CMD_SEND_REQ: begin
            r.action       = ACT_REQUEST;
            r.tx_dest_mac  = BROADCAST_MAC;
            r.tx_op        = TX_OP_REQUEST;
            r.tx_target_ip = it.query_ip;
         end
         default: ;
      endcase
   endtask

   // start stays high after an accept so a zero gap runs back to back
   task automatic send_arp_item(input arp_item_t it);
      int          gap;
      arp_result_t r;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= it.command;
      req_op_code    <= it.op_code;
      req_hw_type    <= it.hw_type;
      req_proto_type <= it.proto_type;
      req_sender_mac <= it.sender_mac;
      req_sender_ip  <= it.sender_ip;
      req_query_ip   <= it.query_ip;
      do @(posedge clock); while (busy !== 1'b0);
      predict_arp_response(it, r);
      pending_responses.push_back(r);
      n_sent++;
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [15:0] op,
                              input logic [15:0] hw, input logic [15:0] proto,
                              input logic [47:0] smac, input logic [31:0] sip,
                              input logic [31:0] qip);
      send_arp_item('{cmd, op, hw, proto, smac, sip, qip});
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_sel, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_OWN_IP) own_ip_cfg = value[31:0];
      else own_mac_cfg = value[47:0];
   endtask

   task automatic set_station(input logic [31:0] ip, input logic [47:0] mac);
      wait_idle();
      write_register(REG_OWN_IP, {$urandom, ip});
      // leave the bus idle between the two writes
      @(posedge clock);
      write_register(REG_OWN_MAC, {$urandom, mac});
      n_settings++;
   endtask

   function automatic logic [31:0] pick_ip();
      if ($urandom_range(0, 3) != 0) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // results are accepted at the edge that ends the strobe cycle
   always @(posedge clock) begin : result_checker
      arp_result_t exp_r;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual action %0h",
                     $time, rsp_action);
            fail_count++;
         end else begin
            exp_r = pending_responses.pop_front();
            check_field("action", 64'(exp_r.action), 64'(rsp_action));
            check_field("tx_dest_mac", 64'(exp_r.tx_dest_mac), 64'(rsp_tx_dest_mac));
            check_field("tx_op", 64'(exp_r.tx_op), 64'(rsp_tx_op));
            check_field("tx_target_ip", 64'(exp_r.tx_target_ip), 64'(rsp_tx_target_ip));
            check_field("found", 64'(exp_r.found), 64'(rsp_found));
            check_field("found_mac", 64'(exp_r.found_mac), 64'(rsp_found_mac));
            check_field("table_full", 64'(exp_r.table_full), 64'(rsp_table_full));
            n_results++;
         end
      end
   end

   task automatic test_directed();
      logic [31:0] me;
      me = 32'hC0A8_0001;
      set_station(me, 48'h0200_0000_0001);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, 32'h0);
      send_fields(CMD_SEND_REQ, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
      send_fields(CMD_SEND_REQ, '0, '0, '0, '0, '0, 32'h0);
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, '1, '1, me);
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, '0, '0, me);
      // request aimed at another station
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 48'h1, 32'h5, me ^ 1);
      // bad hardware type, then bad protocol type
      send_fields(CMD_RX_PACKET, OP_REQUEST, 16'h0006, PROTO_IPV4, 48'h1, 32'h5, me);
      send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, 16'h0806, 48'h1, 32'h5, me);
      send_fields(CMD_RX_PACKET, 16'h0000, HW_ETHERNET, PROTO_IPV4, 48'h1, 32'h5, me);
      send_fields(CMD_RX_PACKET, 16'hFFFF, HW_ETHERNET, PROTO_IPV4, 48'h1, 32'h5, me);
      send_fields(CMD_RX_PACKET, 16'h0003, '1, '1, '1, '1, '1);
      // learn, hit, update, hit again
      send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4, 48'hA1, 32'h0A00_0001, '0);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, 32'h0A00_0001);
      send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4, '1, 32'h0A00_0001, '1);
      send_fields(CMD_LOOKUP, '1, '1, '1, '1, '1, 32'h0A00_0001);
      send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4, '0, 32'h0, '0);
      send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4, '1, 32'hFFFF_FFFF, '0);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, 32'h0);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, 32'h0A00_0002);
      send_fields(CMD_UNUSED, '1, '1, '1, '1, '1, '1);
      send_fields(CMD_UNUSED, '0, HW_ETHERNET, PROTO_IPV4, '0, '0, '0);
   endtask

   task automatic test_station_extremes();
      set_station(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 48'h7, 32'h9, '1);
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 48'h7, 32'h9, '0);
      set_station(32'h0, 48'h0);
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 48'h8, 32'hA, '0);
      send_fields(CMD_RX_PACKET, OP_REQUEST, HW_ETHERNET, PROTO_IPV4, 48'h8, 32'hA, '1);
   endtask

   // mostly well-formed packets over a small address pool so the table
   // fills, sees updates and then starts dropping new senders
   task automatic test_random_traffic();
      arp_item_t it;
      int        pick;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            1: set_station(32'h0, 48'h0);
            2: set_station(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
            3: set_station(ip_pool[$urandom_range(2, POOL_SIZE - 1)],
                           48'({$urandom, $urandom}));
            default: set_station($urandom, 48'({$urandom, $urandom}));
         endcase
         gap_max = (ph == 1) ? 0 : ((ph == 4) ? 3 : 7);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            it.op_code    = 16'($urandom);
            it.hw_type    = 16'($urandom);
            it.proto_type = 16'($urandom);
            it.sender_mac = 48'({$urandom, $urandom});
            it.sender_ip  = pick_ip();
            it.query_ip   = pick_ip();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               it.command = CMD_RX_PACKET;
               if ($urandom_range(0, 9) < 8) begin
                  it.hw_type    = HW_ETHERNET;
                  it.proto_type = PROTO_IPV4;
                  it.op_code    = $urandom_range(0, 1) ? OP_REQUEST : OP_REPLY;
               end else begin
                  // leave header fields random, each forced valid with even odds
                  if ($urandom_range(0, 1)) it.hw_type = HW_ETHERNET;
                  if ($urandom_range(0, 1)) it.proto_type = PROTO_IPV4;
                  if ($urandom_range(0, 1)) it.op_code = 16'($urandom_range(1, 2));
               end
               if ($urandom_range(0, 1)) it.query_ip = own_ip_cfg;
            end else if (pick < 78) begin
               it.command = CMD_LOOKUP;
            end else if (pick < 90) begin
               it.command = CMD_SEND_REQ;
            end else begin
               it.command = CMD_UNUSED;
            end
            send_arp_item(it);
         end
      end
   endtask

   task automatic test_table_overflow();
      gap_max = 7;
      while (held_count < TABLE_ENTRIES) begin
         send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4,
                     48'({$urandom, $urandom}), $urandom, $urandom);
      end
      repeat (2) begin
         send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4,
                     48'({$urandom, $urandom}), $urandom, $urandom);
      end
      // held entries must still update when full
      send_fields(CMD_RX_PACKET, OP_REPLY, HW_ETHERNET, PROTO_IPV4,
                  48'({$urandom, $urandom}), held_ip[TABLE_ENTRIES - 1], '0);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, held_ip[TABLE_ENTRIES - 1]);
      send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0, held_ip[0]);
   endtask

   initial begin
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_station_extremes();
      test_random_traffic();
      test_table_overflow();

      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions under %0d station settings, %0d results checked",
               n_sent, n_settings, n_results);
      $display("Replies sent %0d, lookup hits %0d, inserts dropped on full table %0d",
               n_replies, n_hits, n_drops);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/arp_pkg.sv
src/arp_csr.sv
src/arp_ctrl.sv
src/arp_dpath.sv
src/arp_table_responder.sv
test/tb_arp_table_responder.sv
